// ----- rtl/core/cdadd_pkg.sv -----
// Shared types, constants and microprogram for the calendar date adder.
// No dependencies; imported by every module of the block.
`default_nettype none

package cdadd_pkg;

  // Widths of the working values
  localparam int ADD_BITS  = 16;
  localparam int YEAR_BITS = 16;
  localparam int DAY_W     = ((ADD_BITS > 11) ? ADD_BITS : 11) + 1;

  // Calendar constants
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_DEC  = 4'd12;
  localparam int         QUAD_DAYS  = 1461;  // days in any 48 consecutive months
  localparam int         QUAD_LIMIT = 1492;  // skip four years while above this
  localparam int         QUAD_YEARS = 4;

  // Micro-operations executed by the datapath
  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_ADD,
    UOP_SUBQ,
    UOP_SUBM,
    UOP_EMIT
  } uop_e;

  // Branch conditions tested by the sequencer
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_BAD,
    COND_QUAD,
    COND_MONTH,
    COND_OUT_FREE
  } cond_e;

  localparam int UPC_W       = 3;
  localparam int UCODE_DEPTH = 1 << UPC_W;
  typedef logic [UPC_W-1:0] upc_t;

  // Program steps
  localparam upc_t PC_WAIT  = 3'd0;
  localparam upc_t PC_CHECK = 3'd1;
  localparam upc_t PC_ADD   = 3'd2;
  localparam upc_t PC_QUAD  = 3'd3;
  localparam upc_t PC_MONTH = 3'd4;
  localparam upc_t PC_EMIT  = 3'd5;

  // One control word: the op runs when the condition holds
  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  pc_true;
    upc_t  pc_false;
  } ucode_t;

  localparam ucode_t UCODE [UCODE_DEPTH] = '{
    '{UOP_LOAD, COND_IN_VALID, PC_CHECK, PC_WAIT },
    '{UOP_NOP,  COND_BAD,      PC_EMIT,  PC_ADD  },
    '{UOP_ADD,  COND_ALWAYS,   PC_QUAD,  PC_QUAD },
    '{UOP_SUBQ, COND_QUAD,     PC_QUAD,  PC_MONTH},
    '{UOP_SUBM, COND_MONTH,    PC_MONTH, PC_EMIT },
    '{UOP_EMIT, COND_OUT_FREE, PC_WAIT,  PC_EMIT },
    '{UOP_NOP,  COND_ALWAYS,   PC_WAIT,  PC_WAIT },
    '{UOP_NOP,  COND_ALWAYS,   PC_WAIT,  PC_WAIT }
  };

  // Control from sequencer to datapath
  typedef struct packed {
    uop_e uop;
    logic exec;
  } ctrl_t;

  // Status from datapath and handshake to sequencer
  typedef struct packed {
    logic in_valid;
    logic bad;
    logic day_gt_quad;
    logic day_gt_month;
    logic out_free;
  } status_t;

  // Length of a month; February is leap when the year is a multiple of four
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      unique case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cdadd_useq.sv -----
// Microcode sequencer: step counter, program table and branch logic.
// Depends on cdadd_pkg.
`default_nettype none

module cdadd_useq
  import cdadd_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    in_ready_o
);

  upc_t   pc_q, pc_d;
  ucode_t word;
  logic   cond_ok;

  // Fetch and evaluate the branch condition
  always_comb begin
    word = UCODE[pc_q];
    unique case (word.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_IN_VALID: cond_ok = status_i.in_valid;
      COND_BAD:      cond_ok = status_i.bad;
      COND_QUAD:     cond_ok = status_i.day_gt_quad;
      COND_MONTH:    cond_ok = status_i.day_gt_month;
      COND_OUT_FREE: cond_ok = status_i.out_free;
      default:       cond_ok = 1'b0;
    endcase
    pc_d        = cond_ok ? word.pc_true : word.pc_false;
    ctrl_o.uop  = word.uop;
    ctrl_o.exec = cond_ok;
    in_ready_o  = (word.uop == UOP_LOAD);
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cdadd_datapath.sv -----
// Datapath: day, month and year working registers and the result register.
// Depends on cdadd_pkg; driven by cdadd_useq control words.
`default_nettype none

module cdadd_datapath
  import cdadd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  ctrl_t       ctrl_i,
  input  wire  [4:0]  start_day_i,
  input  wire  [3:0]  start_month_i,
  input  wire  [15:0] start_year_i,
  input  wire  [15:0] days_to_add_i,
  input  wire         out_ready_i,
  output logic        bad_o,
  output logic        day_gt_quad_o,
  output logic        day_gt_month_o,
  output logic        out_free_o,
  output logic        out_valid_o,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [15:0] result_year_o,
  output logic        bad_month_o,
  output logic        year_wrapped_o
);

  localparam int YEAR_W1 = YEAR_BITS + 1;

  logic [DAY_W-1:0]     day_q;
  logic [3:0]           month_q;
  logic [YEAR_BITS-1:0] year_q;
  logic [ADD_BITS-1:0]  days_q;
  logic                 bad_q, wrap_q;

  logic [4:0]           res_day_q;
  logic [3:0]           res_month_q;
  logic [15:0]          res_year_q;
  logic                 res_bad_q, res_wrap_q, out_valid_q, out_valid_d;

  logic [4:0]           mlen;
  logic [YEAR_W1-1:0]   year_sum;
  logic                 run;

  // Month length, comparisons and the shared year adder
  always_comb begin
    mlen           = month_len(month_q, year_q[1:0] == 2'b00);
    day_gt_month_o = day_q > DAY_W'(mlen);
    day_gt_quad_o  = day_q > DAY_W'(QUAD_LIMIT);
    year_sum       = {1'b0, year_q}
                   + ((ctrl_i.uop == UOP_SUBQ) ? YEAR_W1'(QUAD_YEARS) : YEAR_W1'(1));
    run            = ctrl_i.exec;
    out_free_o     = !out_valid_q || out_ready_i;
    bad_o          = bad_q;
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (run) begin
      unique case (ctrl_i.uop)
        UOP_LOAD: begin
          day_q   <= DAY_W'(start_day_i);
          month_q <= start_month_i;
          year_q  <= YEAR_BITS'(start_year_i);
          days_q  <= ADD_BITS'(days_to_add_i);
          bad_q   <= (start_month_i < MONTH_JAN) || (start_month_i > MONTH_DEC);
          wrap_q  <= 1'b0;
        end
        UOP_ADD: begin
          day_q <= day_q + DAY_W'(days_q);
        end
        UOP_SUBQ: begin
          day_q  <= day_q - DAY_W'(QUAD_DAYS);
          year_q <= year_sum[YEAR_BITS-1:0];
          wrap_q <= wrap_q | year_sum[YEAR_BITS];
        end
        UOP_SUBM: begin
          day_q <= day_q - DAY_W'(mlen);
          if (month_q == MONTH_DEC) begin
            month_q <= MONTH_JAN;
            year_q  <= year_sum[YEAR_BITS-1:0];
            wrap_q  <= wrap_q | year_sum[YEAR_BITS];
          end else begin
            month_q <= month_q + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register; takes a new item once the previous one is gone
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (run && ctrl_i.uop == UOP_EMIT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && ctrl_i.uop == UOP_EMIT) begin
      res_day_q   <= day_q[4:0];
      res_month_q <= month_q;
      res_year_q  <= 16'(year_q);
      res_bad_q   <= bad_q;
      res_wrap_q  <= wrap_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_day_o   = res_day_q;
  assign result_month_o = res_month_q;
  assign result_year_o  = res_year_q;
  assign bad_month_o    = res_bad_q;
  assign year_wrapped_o = res_wrap_q;

endmodule

`default_nettype wire

// ----- rtl/core/calendar_date_adder.sv -----
// Top level of the calendar date adder: microcode sequencer plus datapath.
// Depends on cdadd_pkg, cdadd_useq and cdadd_datapath.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_ready_o | start_day, start_month, start_year,
//           |           |                         | days_to_add
//   out     | output    | out_valid_o/out_ready_i | result_day, result_month,
//           |           |                         | result_year, bad_month, year_wrapped
//
// One item at a time. An item runs the load, check and add steps, then four-year skips
// while the running day count exceeds 1492 (at most 44), then month steps while the day
// exceeds the month length (at most 49), for a 16-bit day count, and then the emit step.
// A bad month skips straight from the check step to the result.
// Reset clears the step counter and the result valid flag only.
// A stalled result holds in its register; the next item waits at the emit step.
`default_nettype none

module calendar_date_adder
  import cdadd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [4:0]  start_day_i,
  input  wire  [3:0]  start_month_i,
  input  wire  [15:0] start_year_i,
  input  wire  [15:0] days_to_add_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [15:0] result_year_o,
  output logic        bad_month_o,
  output logic        year_wrapped_o
);

  ctrl_t   ctrl;
  status_t status;
  logic    bad, day_gt_quad, day_gt_month, out_free;

  assign status = '{
    in_valid:     in_valid_i,
    bad:          bad,
    day_gt_quad:  day_gt_quad,
    day_gt_month: day_gt_month,
    out_free:     out_free
  };

  cdadd_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  cdadd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .days_to_add_i  (days_to_add_i),
    .out_ready_i    (out_ready_i),
    .bad_o          (bad),
    .day_gt_quad_o  (day_gt_quad),
    .day_gt_month_o (day_gt_month),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .bad_month_o    (bad_month_o),
    .year_wrapped_o (year_wrapped_o)
  );

  // An accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("input ready straight after an accepted item");

  // A passed-through bad month never reports a year wrap
  a_bad_no_wrap: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_month_o |-> !year_wrapped_o
  ) else $error("bad month item flagged a year wrap");

  // A good item ends in a real month
  a_month_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_month_o |->
      (result_month_o >= MONTH_JAN) && (result_month_o <= MONTH_DEC)
  ) else $error("result month out of range");

endmodule

`default_nettype wire
